>>> rtl/m3uf_pkg.sv
`default_nettype none
package m3uf_pkg;

  localparam int DEF_MAX_ELEMENTS = 65536;
  localparam logic [15:0] NUM_ELEMENTS_RST = 16'hFFFF;

  localparam logic [1:0] REASON_MERGED = 2'd0;
  localparam logic [1:0] REASON_KNOWN  = 2'd1;
  localparam logic [1:0] REASON_RANGE  = 2'd2;
  localparam logic [1:0] REASON_CONTRA = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] elem_a;
    logic [15:0] elem_b;
  } in_t;

  typedef struct packed {
    logic        is_false;
    logic [1:0]  reason;
    logic [31:0] false_count;
  } out_t;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_CHK, S_P2RD, S_P2WR, S_LINK, S_DONE
  } state_t;

  // mod-3 add of residues 0..2
  function automatic logic [1:0] add3(input logic [1:0] x, input logic [1:0] y);
    logic [2:0] s;
    s = {1'b0, x} + {1'b0, y};
    add3 = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  function automatic logic [1:0] sub3(input logic [1:0] x, input logic [1:0] y);
    logic [1:0] ny;
    ny = (y == 2'd0) ? 2'd0 : 2'(2'd3 - y);
    sub3 = add3(x, ny);
  endfunction

endpackage
`default_nettype wire

>>> rtl/m3uf_ram.sv
`default_nettype none
module m3uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/mod3_relation_union_find_unit.sv
`default_nettype none
// Weighted union-find over mod-3 offsets. Each transaction states that two
// elements are in the same class (op 0) or that elem_a is one step ahead of
// elem_b mod 3 (op 1); the result tells whether it merged two classes, agreed
// with what is known, had an index above num_elements or outside the RAM, or
// contradicted the stored offsets, along with a saturating count of false
// statements. Links and offsets live in one RAM with a registered read. A
// statement walks from elem_a and then from elem_b to the root: the search
// reads one link per cycle, and unless the element is its own root a
// compression pass follows, which after a read turnaround state rewrites one
// link per cycle to point at the root. The roots are then compared or linked.
// An out-of-range statement skips the walks. A result still waiting on
// out_ready holds the block in its final state. After reset every RAM entry
// is initialized to point at itself before the first transaction is accepted.
module mod3_relation_union_find_unit #(
  parameter int MAX_ELEMENTS = m3uf_pkg::DEF_MAX_ELEMENTS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire m3uf_pkg::in_t      in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output m3uf_pkg::out_t          out_data,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata
);
  import m3uf_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int ENT_W = IDX_W + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMENTS - 1);

  state_t state_r, state_nxt;
  logic [15:0] num_r;
  in_t in_r, in_nxt;
  logic sel_b_r, sel_b_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt, node_r, node_nxt, root_r, root_nxt, ra_r, ra_nxt;
  logic [1:0] acc_r, acc_nxt, rem_r, rem_nxt, da_r, da_nxt;
  logic [1:0] reason_r, reason_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;

  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [ENT_W-1:0] wdata, rdata;
  logic [IDX_W-1:0] rd_par;
  logic [1:0] rd_off;
  logic fin;
  logic [IDX_W-1:0] fin_root;
  logic bad_a, bad_b, is_bad;

  m3uf_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ELEMENTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rd_par = rdata[ENT_W-1:2];
  assign rd_off = rdata[1:0];
  assign bad_a = (in_data.elem_a > num_r) || (32'(in_data.elem_a) >= 32'(MAX_ELEMENTS));
  assign bad_b = (in_data.elem_b > num_r) || (32'(in_data.elem_b) >= 32'(MAX_ELEMENTS));
  assign is_bad = (reason_r == REASON_RANGE) || (reason_r == REASON_CONTRA);

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      num_r       <= NUM_ELEMENTS_RST;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sel_b_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sel_b_r     <= sel_b_nxt;
      if (cfg_we) begin
        num_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r     <= in_nxt;
    cur_r    <= cur_nxt;
    node_r   <= node_nxt;
    root_r   <= root_nxt;
    ra_r     <= ra_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    da_r     <= da_nxt;
    reason_r <= reason_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    sel_b_nxt     = sel_b_r;
    cur_nxt       = cur_r;
    node_nxt      = node_r;
    root_nxt      = root_r;
    ra_nxt        = ra_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    da_nxt        = da_r;
    reason_nxt    = reason_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    waddr         = cur_r;
    wdata         = {root_r, rem_r};
    raddr         = cur_r;
    fin           = 1'b0;
    fin_root      = root_r;

    unique case (state_r)
      S_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = {clr_r, 2'd0};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          sel_b_nxt = 1'b0;
          node_nxt  = IDX_W'(in_data.elem_a);
          cur_nxt   = IDX_W'(in_data.elem_a);
          acc_nxt   = 2'd0;
          if (bad_a || bad_b) begin
            reason_nxt = REASON_RANGE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (rd_par == cur_r) begin
          root_nxt = cur_r;
          rem_nxt  = acc_r;
          if (cur_r == node_r) begin
            fin      = 1'b1;
            fin_root = cur_r;
          end else begin
            cur_nxt   = node_r;
            state_nxt = S_P2RD;
          end
        end else begin
          // follow the link, summing offsets
          acc_nxt = add3(acc_r, rd_off);
          cur_nxt = rd_par;
          raddr   = rd_par;
        end
      end
      S_P2RD: begin
        state_nxt = S_P2WR;
      end
      S_P2WR: begin
        // point this node straight at the root
        we      = 1'b1;
        rem_nxt = sub3(rem_r, rd_off);
        cur_nxt = rd_par;
        raddr   = rd_par;
        if (rd_par == root_r) begin
          fin = 1'b1;
        end
      end
      S_LINK: begin
        if (ra_r == root_r) begin
          reason_nxt = (sub3(da_r, acc_r) == {1'b0, in_r.op}) ? REASON_KNOWN
                                                               : REASON_CONTRA;
        end else begin
          we         = 1'b1;
          waddr      = ra_r;
          wdata      = {root_r, add3(sub3(acc_r, da_r), {1'b0, in_r.op})};
          reason_nxt = REASON_MERGED;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          if (is_bad && (cnt_r != 32'hFFFF_FFFF)) begin
            cnt_nxt = cnt_r + 32'd1;
          end
          out_valid_nxt        = 1'b1;
          out_nxt.is_false     = is_bad;
          out_nxt.reason       = reason_r;
          out_nxt.false_count  = (is_bad && (cnt_r != 32'hFFFF_FFFF)) ? cnt_r + 32'd1
                                                                      : cnt_r;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      if (!sel_b_r) begin
        ra_nxt    = fin_root;
        da_nxt    = acc_r;
        sel_b_nxt = 1'b1;
        node_nxt  = IDX_W'(in_r.elem_b);
        cur_nxt   = IDX_W'(in_r.elem_b);
        acc_nxt   = 2'd0;
        state_nxt = S_RD;
      end else begin
        root_nxt  = fin_root;
        state_nxt = S_LINK;
      end
    end
  end

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import m3uf_pkg::*;

  localparam int NODES = 65536;
  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mod3_relation_union_find_unit #(.MAX_ELEMENTS(NODES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [15:0] link_of [NODES];
  logic [1:0] ofs_of [NODES];
  logic [31:0] false_tally;
  logic [15:0] top_index;

  out_t verdict_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic [1:0] mod3_sum(logic [1:0] x, logic [1:0] y);
    return 2'((int'(x) + int'(y)) % 3);
  endfunction

  function automatic logic [1:0] mod3_diff(logic [1:0] x, logic [1:0] y);
    return 2'((int'(x) + 3 - int'(y)) % 3);
  endfunction

  // two-pass root search with path compression
  function automatic logic [15:0] root_of(logic [15:0] node, output logic [1:0] root_ofs);
    logic [15:0] cur, root, nxt;
    logic [1:0] acc, rem, own;
    cur = node;
    acc = 2'd0;
    while (link_of[cur] != cur) begin
      acc = mod3_sum(acc, ofs_of[cur]);
      cur = link_of[cur];
    end
    root = cur;
    rem = acc;
    cur = node;
    while (cur != root) begin
      nxt = link_of[cur];
      own = ofs_of[cur];
      link_of[cur] = root;
      ofs_of[cur] = rem;
      rem = mod3_diff(rem, own);
      cur = nxt;
    end
    root_ofs = acc;
    return root;
  endfunction

  function automatic out_t judge(in_t s);
    out_t r;
    logic [15:0] ra, rb;
    logic [1:0] da, db, why;
    if (s.elem_a > top_index || s.elem_b > top_index) begin
      why = REASON_RANGE;
    end else begin
      ra = root_of(s.elem_a, da);
      rb = root_of(s.elem_b, db);
      if (ra == rb) begin
        why = (mod3_diff(da, db) == {1'b0, s.op}) ? REASON_KNOWN : REASON_CONTRA;
      end else begin
        link_of[ra] = rb;
        ofs_of[ra] = mod3_sum(mod3_diff(db, da), {1'b0, s.op});
        why = REASON_MERGED;
      end
    end
    if (why >= REASON_RANGE && false_tally != 32'hFFFF_FFFF) false_tally++;
    r.is_false = (why >= REASON_RANGE);
    r.reason = why;
    r.false_count = false_tally;
    return r;
  endfunction

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", out_data);
      end else begin
        exp_r = verdict_q.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", exp_r, out_data);
        end
      end
    end
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || ($time % 5000 < 1500);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(in_t s, bit has_exp, out_t exp_r);
    out_t p;
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    p = judge(s);
    if (has_exp && p !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %p vs %p", exp_r, p);
    end
    verdict_q.push_back(p);
  endtask

  task automatic gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_top(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    top_index = v;
  endtask

  function automatic in_t stmt(bit o, int a, int b);
    in_t s;
    s.op = o;
    s.elem_a = 16'(a);
    s.elem_b = 16'(b);
    return s;
  endfunction

  function automatic out_t verdict(bit f, logic [1:0] r, int c);
    out_t v;
    v.is_false = f;
    v.reason = r;
    v.false_count = 32'(c);
    return v;
  endfunction

  typedef struct {
    in_t s;
    bit has_exp;
    out_t v;
  } row_t;

  task automatic random_phase(int n, int span, bit well_formed);
    int burst;
    in_t s;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        gap();
        burst = $urandom_range(1, 30);
      end
      burst--;
      s.op = 1'($urandom);
      if (well_formed) begin
        s.elem_a = 16'($urandom_range(0, span));
        s.elem_b = 16'($urandom_range(0, span));
      end else begin
        s.elem_a = 16'($urandom);
        s.elem_b = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, span));
      end
      send(s, 1'b0, '0);
    end
  endtask

  initial begin
    row_t rows[$];
    for (int i = 0; i < NODES; i++) begin
      link_of[i] = 16'(i);
      ofs_of[i] = 2'd0;
    end
    false_tally = '0;
    top_index = NUM_ELEMENTS_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset range, self relations, merges, contradictions
    rows.push_back('{stmt(0, 0, 0), 1, verdict(0, REASON_KNOWN, 0)});
    rows.push_back('{stmt(1, 7, 7), 1, verdict(1, REASON_CONTRA, 1)});
    rows.push_back('{stmt(0, 65535, 0), 1, verdict(0, REASON_MERGED, 1)});
    rows.push_back('{stmt(1, 1, 2), 1, verdict(0, REASON_MERGED, 1)});
    rows.push_back('{stmt(1, 2, 3), 0, '0});
    rows.push_back('{stmt(1, 3, 1), 0, '0});
    rows.push_back('{stmt(0, 1, 3), 0, '0});
    rows.push_back('{stmt(1, 1, 3), 0, '0});
    rows.push_back('{stmt(0, 65535, 0), 0, '0});
    rows.push_back('{stmt(1, 65535, 32768), 0, '0});
    rows.push_back('{stmt(1, 21845, 43690), 0, '0});
    foreach (rows[i]) send(rows[i].s, rows[i].has_exp, rows[i].v);
    drain();

    // range checks at the extremes of the register
    set_top(16'd0);
    rows.delete();
    rows.push_back('{stmt(0, 0, 0), 0, '0});
    rows.push_back('{stmt(1, 0, 0), 0, '0});
    rows.push_back('{stmt(0, 1, 0), 0, '0});
    rows.push_back('{stmt(0, 0, 65535), 0, '0});
    rows.push_back('{stmt(1, 65535, 65535), 0, '0});
    foreach (rows[i]) send(rows[i].s, rows[i].has_exp, rows[i].v);
    drain();
    set_top(16'd1);
    send(stmt(1, 1, 0), 1'b0, '0);
    send(stmt(1, 2, 0), 1'b0, '0);
    drain();

    // random: small sets, one of them under a receiver stall, noise over the full range, then a random top
    set_top(16'd40);
    random_phase(350, 45, 1'b1);
    drain();
    set_top(16'd300);
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(400, 320, 1'b1);
    join
    drain();
    set_top(16'd65535);
    random_phase(300, 200, 1'b0);
    drain();
    set_top(16'($urandom_range(1000, 60000)));
    random_phase(300, 2000, 1'b1);
    drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/m3uf_pkg.sv
rtl/m3uf_ram.sv
rtl/mod3_relation_union_find_unit.sv
dv/testbench.sv
